>>> design/alkm_pkg.sv
// ----------------------------------------------------------------------------
// alkm_pkg
// Shared types and constants of the append log with k-th recent match queries.
// ----------------------------------------------------------------------------
package alkm_pkg;

  localparam int LOG_DEPTH = 1024;
  localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int SEQ_W     = 10;
  localparam int POS_W     = 10;
  localparam int CMP_W     = (CNT_W > SEQ_W) ? CNT_W : SEQ_W;
  localparam int TIME_W    = 64;
  localparam int LEN_W     = 16;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_BY_SEQ      = 3'd1,
    OP_BY_TASK     = 3'd2,
    OP_BY_TYPE     = 3'd3,
    OP_TASK_SENDER = 3'd4,
    OP_TYPE_SENDER = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  // stored key: type in the top byte, then task, then sender
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [15:0] task_id;
    logic [15:0] sender_id;
  } key_t;

  localparam int KEY_W = $bits(key_t);

endpackage

>>> design/alkm_ram.sv
// ----------------------------------------------------------------------------
// alkm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module alkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/alkm_match.sv
// ----------------------------------------------------------------------------
// alkm_match
// Match compare unit: tests one stored key against the query criteria.
// ----------------------------------------------------------------------------
module alkm_match (
  input  alkm_pkg::op_e  op_i,
  input  alkm_pkg::key_t key_i,
  input  alkm_pkg::key_t crit_i,
  output logic           hit_o
);

  logic task_ok;
  logic type_ok;
  logic sender_ok;

  assign task_ok   = (key_i.task_id == crit_i.task_id);
  assign type_ok   = (key_i.msg_type == crit_i.msg_type);
  assign sender_ok = (key_i.sender_id == crit_i.sender_id);

  always_comb begin
    unique case (op_i)
      alkm_pkg::OP_BY_TASK:     hit_o = task_ok;
      alkm_pkg::OP_BY_TYPE:     hit_o = type_ok;
      alkm_pkg::OP_TASK_SENDER: hit_o = task_ok & sender_ok;
      alkm_pkg::OP_TYPE_SENDER: hit_o = type_ok & sender_ok;
      default:                  hit_o = 1'b0;
    endcase
  end

endmodule

>>> design/append_log_kth_recent_match_core.sv
// ----------------------------------------------------------------------------
// append_log_kth_recent_match_core
// Append-only log with lookup by sequence and k-th newest match queries.
// ----------------------------------------------------------------------------
// append and lookup by sequence go from the accept straight to the response state
// match queries scan newest to oldest, one entry per cycle through the ram
// read port and the compare unit, then go to the response state
// one request at a time, taken once the result register is loaded; the result
// register waits while the output holds a result that is not yet taken
// reset clears the entry count, the sequencer and the output valid; rams are not
// ----------------------------------------------------------------------------
module append_log_kth_recent_match_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         msg_type_i,
  input  logic [15:0]        task_id_i,
  input  logic [15:0]        sender_id_i,
  input  logic signed [63:0] timestamp_i,
  input  logic [15:0]        content_len_i,
  input  logic [9:0]         seq_query_i,
  input  logic [9:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [9:0]         seq_out_o,
  output logic [7:0]         type_out_o,
  output logic [15:0]        task_out_o,
  output logic [15:0]        sender_out_o,
  output logic signed [63:0] time_out_o,
  output logic [15:0]        length_out_o
);

  localparam int AW = alkm_pkg::ADDR_W;
  localparam int CW = alkm_pkg::CNT_W;

  alkm_pkg::state_e state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q, out_valid_d;

  // request context
  alkm_pkg::op_e                op_q, op_d;
  alkm_pkg::key_t               crit_q, crit_d;
  logic [alkm_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [alkm_pkg::POS_W-1:0]   seen_q, seen_d;
  logic [AW-1:0]                next_addr_q, next_addr_d;
  logic [AW-1:0]                slot_q, slot_d;
  logic                         more_q, more_d;
  alkm_pkg::status_e            res_status_q, res_status_d;
  logic [alkm_pkg::SEQ_W-1:0]   res_seq_q, res_seq_d;
  logic                         found_q, found_d;

  // result register
  alkm_pkg::status_e            status_q;
  logic [alkm_pkg::SEQ_W-1:0]   seq_q;
  alkm_pkg::key_t               key_out_q;
  logic [alkm_pkg::TIME_W-1:0]  time_q;
  logic [alkm_pkg::LEN_W-1:0]   len_q;
  logic                         load_out;

  // ram ports
  logic                         we;
  logic [AW-1:0]                waddr;
  logic                         re;
  logic [AW-1:0]                raddr;
  alkm_pkg::key_t               wkey;
  alkm_pkg::key_t               rkey;
  logic [alkm_pkg::TIME_W-1:0]  rtime;
  logic [alkm_pkg::LEN_W-1:0]   rlen;

  logic                         accept;
  logic                         hit;
  logic                         full;
  logic                         seq_ok;
  alkm_pkg::op_e                in_op;
  logic [AW-1:0]                top_addr;

  assign in_ready_o = (state_q == alkm_pkg::S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_op      = alkm_pkg::op_e'(operation_i);
  assign full       = (count_q == CW'(alkm_pkg::LOG_DEPTH));
  assign seq_ok     = (alkm_pkg::CMP_W'(seq_query_i) < alkm_pkg::CMP_W'(count_q));
  assign top_addr   = AW'(count_q - CW'(1));
  assign waddr      = AW'(count_q);

  assign wkey.msg_type  = msg_type_i;
  assign wkey.task_id   = task_id_i;
  assign wkey.sender_id = sender_id_i;

  alkm_ram #(.WIDTH(alkm_pkg::KEY_W), .DEPTH(alkm_pkg::LOG_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wkey),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rkey)
  );

  alkm_ram #(.WIDTH(alkm_pkg::TIME_W), .DEPTH(alkm_pkg::LOG_DEPTH)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (timestamp_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rtime)
  );

  alkm_ram #(.WIDTH(alkm_pkg::LEN_W), .DEPTH(alkm_pkg::LOG_DEPTH)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (content_len_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rlen)
  );

  alkm_match u_match (
    .op_i   (op_q),
    .key_i  (rkey),
    .crit_i (crit_q),
    .hit_o  (hit)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    op_d         = op_q;
    crit_d       = crit_q;
    pos_d        = pos_q;
    seen_d       = seen_q;
    next_addr_d  = next_addr_q;
    slot_d       = slot_q;
    more_d       = more_q;
    res_status_d = res_status_q;
    res_seq_d    = res_seq_q;
    found_d      = found_q;
    we           = 1'b0;
    re           = 1'b0;
    raddr        = next_addr_q;
    load_out     = 1'b0;

    unique case (state_q)
      alkm_pkg::S_IDLE: begin
        if (accept) begin
          op_d               = in_op;
          crit_d.msg_type    = msg_type_i;
          crit_d.task_id     = task_id_i;
          crit_d.sender_id   = sender_id_i;
          pos_d              = position_i;
          seen_d             = '0;
          found_d            = 1'b0;
          res_seq_d          = '0;
          res_status_d       = alkm_pkg::ST_NOMATCH;
          state_d            = alkm_pkg::S_RESP;
          unique case (in_op) inside
            alkm_pkg::OP_APPEND: begin
              if (full) begin
                res_status_d = alkm_pkg::ST_FULL;
              end else begin
                we           = 1'b1;
                count_d      = count_q + CW'(1);
                res_status_d = alkm_pkg::ST_OK;
                res_seq_d    = alkm_pkg::SEQ_W'(count_q);
              end
            end
            alkm_pkg::OP_BY_SEQ: begin
              if (seq_ok) begin
                re           = 1'b1;
                raddr        = AW'(seq_query_i);
                found_d      = 1'b1;
                res_status_d = alkm_pkg::ST_OK;
                res_seq_d    = seq_query_i;
              end
            end
            alkm_pkg::OP_BY_TASK, alkm_pkg::OP_BY_TYPE,
            alkm_pkg::OP_TASK_SENDER, alkm_pkg::OP_TYPE_SENDER: begin
              if (count_q != '0) begin
                // newest entry goes out now, the compare sees it next cycle
                re          = 1'b1;
                raddr       = top_addr;
                slot_d      = top_addr;
                next_addr_d = top_addr - AW'(1);
                more_d      = (top_addr != '0);
                state_d     = alkm_pkg::S_SCAN;
              end
            end
            default: begin
              res_status_d = alkm_pkg::ST_NOMATCH;
            end
          endcase
        end
      end

      alkm_pkg::S_SCAN: begin
        if (hit && (seen_q == pos_q)) begin
          // hold the ram output on the matching entry
          found_d      = 1'b1;
          res_status_d = alkm_pkg::ST_OK;
          res_seq_d    = alkm_pkg::SEQ_W'(slot_q);
          state_d      = alkm_pkg::S_RESP;
        end else begin
          if (hit) begin
            seen_d = seen_q + alkm_pkg::POS_W'(1);
          end
          if (more_q) begin
            re          = 1'b1;
            raddr       = next_addr_q;
            slot_d      = next_addr_q;
            next_addr_d = next_addr_q - AW'(1);
            more_d      = (next_addr_q != '0);
          end else begin
            state_d = alkm_pkg::S_RESP;
          end
        end
      end

      alkm_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = alkm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = alkm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alkm_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    crit_q       <= crit_d;
    pos_q        <= pos_d;
    seen_q       <= seen_d;
    next_addr_q  <= next_addr_d;
    slot_q       <= slot_d;
    more_q       <= more_d;
    res_status_q <= res_status_d;
    res_seq_q    <= res_seq_d;
    found_q      <= found_d;
    if (load_out) begin
      status_q <= res_status_q;
      seq_q    <= res_seq_q;
      if (found_q) begin
        key_out_q <= rkey;
        time_q    <= rtime;
        len_q     <= rlen;
      end else begin
        key_out_q <= '0;
        time_q    <= '0;
        len_q     <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign seq_out_o    = seq_q;
  assign type_out_o   = key_out_q.msg_type;
  assign task_out_o   = key_out_q.task_id;
  assign sender_out_o = key_out_q.sender_id;
  assign time_out_o   = $signed(time_q);
  assign length_out_o = len_q;

endmodule
